[rtl/triangle_scanline_fill_assert.svh]
// assertion macros for the triangle scanline fill checker
// expects clk and arst_n in the scope of each use
`ifndef TRIANGLE_SCANLINE_FILL_ASSERT_SVH
`define TRIANGLE_SCANLINE_FILL_ASSERT_SVH

// condition and consequence in the same cycle
`define TSF_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsf: same-cycle check failed");

// consequence in the cycle after the condition
`define TSF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsf: next-cycle check failed");

`endif

[rtl/tsf_pkg.sv]
// shared widths, defaults and the fill job type of the triangle scanline fill
// no dependencies
`timescale 1ns / 1ps

package tsf_pkg;

	localparam int XW = 10;
	localparam int YW = 6;

	localparam int SCREEN_WIDTH_DEF = 1024;
	localparam int BAND_ROWS_DEF    = 64;
	localparam int FRAC_BITS_DEF    = 16;

	localparam int IN_W  = 48;
	localparam int OUT_W = 32;

	// rounded cut point: magnitude of 2*num+den and divisor 2*den
	localparam int CUT_NW = 17;
	localparam int CUT_DW = 7;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef struct packed {
		logic [XW-1:0] apex_x;
		logic [XW-1:0] p_x;
		logic [XW-1:0] q_x;
		logic [YW-1:0] p_y;
		logic [YW-1:0] rows;
		logic          up;
		logic          last;
	} fill_t;

endpackage

[rtl/tsf_fifo.sv]
// short queue of fill jobs between front and back
// depends on tsf_pkg
`timescale 1ns / 1ps

module tsf_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  tsf_pkg::fill_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output tsf_pkg::fill_t rd_data
);

	tsf_pkg::fill_t mem_q [tsf_pkg::QDEPTH];
	logic [tsf_pkg::QAW:0] wr_ptr_q;
	logic [tsf_pkg::QAW:0] rd_ptr_q;
	logic                  empty;
	logic                  full;

	assign empty    = (wr_ptr_q == rd_ptr_q);
	assign full     = (wr_ptr_q[tsf_pkg::QAW] != rd_ptr_q[tsf_pkg::QAW]) &&
	                  (wr_ptr_q[tsf_pkg::QAW-1:0] == rd_ptr_q[tsf_pkg::QAW-1:0]);
	assign wr_ready = !full;
	assign rd_valid = !empty;
	assign rd_data  = mem_q[rd_ptr_q[tsf_pkg::QAW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_valid && !full)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_ready && !empty)
				rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_valid && !full)
			mem_q[wr_ptr_q[tsf_pkg::QAW-1:0]] <= wr_data;
	end

endmodule

[rtl/tsf_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps

module tsf_div #(
	parameter int NW = 17,
	parameter int DW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	assign done = done_q;
	assign quot = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

endmodule

[rtl/tsf_front.sv]
// front end: takes a triangle, classifies it and issues zero, one or two fill jobs
// depends on tsf_pkg and tsf_div
`timescale 1ns / 1ps

module tsf_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [tsf_pkg::IN_W-1:0] s_tdata,
	output logic                     job_valid,
	input  logic                     job_ready,
	output tsf_pkg::fill_t           job
);

	localparam int XW = tsf_pkg::XW;
	localparam int YW = tsf_pkg::YW;

	typedef enum logic [2:0] {
		F_IDLE,
		F_CLASS,
		F_START,
		F_WAIT,
		F_PUSH1,
		F_PUSH2
	} fstate_t;

	fstate_t state_q;

	logic [XW-1:0] x_q [3];
	logic [YW-1:0] y_q [3];
	logic [XW-1:0] sx_q [3];
	logic [YW-1:0] sy_q [3];
	logic signed [18:0] n_q;
	logic [tsf_pkg::CUT_DW-1:0] d_q;
	tsf_pkg::fill_t job_q;
	tsf_pkg::fill_t job2_q;

	logic eq12, eq13, eq23, all_eq, any_eq;
	logic [XW-1:0] sx [3];
	logic [YW-1:0] sy [3];
	logic signed [18:0] n_c;
	tsf_pkg::fill_t flat_job;
	tsf_pkg::fill_t job1_c;
	tsf_pkg::fill_t job2_c;
	logic div_start;
	logic div_done;
	logic [tsf_pkg::CUT_NW-1:0] div_num;
	logic [tsf_pkg::CUT_NW-1:0] div_quot;
	logic signed [18:0] q_s;
	logic [18:0] cut_sum;

	always_comb begin
		logic [XW-1:0] tx;
		logic [YW-1:0] ty;
		logic signed [XW:0] dxc;
		logic signed [YW:0] dyc;
		logic signed [YW:0] dyf;
		logic [XW-1:0] ax_f, px_f, qx_f;
		logic [YW-1:0] ay_f, py_f;
		tx     = '0;
		ty     = '0;
		eq12   = (y_q[0] == y_q[1]);
		eq13   = (y_q[0] == y_q[2]);
		eq23   = (y_q[1] == y_q[2]);
		all_eq = eq12 && eq13;
		any_eq = eq12 || eq13 || eq23;

		// sort by row
		sx = x_q;
		sy = y_q;
		if (sy[0] > sy[1]) begin
			tx = sx[0]; sx[0] = sx[1]; sx[1] = tx;
			ty = sy[0]; sy[0] = sy[1]; sy[1] = ty;
		end
		if (sy[1] > sy[2]) begin
			tx = sx[1]; sx[1] = sx[2]; sx[2] = tx;
			ty = sy[1]; sy[1] = sy[2]; sy[2] = ty;
		end
		if (sy[0] > sy[1]) begin
			tx = sx[0]; sx[0] = sx[1]; sx[1] = tx;
			ty = sy[0]; sy[0] = sy[1]; sy[1] = ty;
		end
		dxc = signed'({1'b0, sx[2]}) - signed'({1'b0, sx[0]});
		dyc = signed'({1'b0, sy[1] - sy[0]});
		n_c = 19'(dxc * dyc) * 19'sd2 + 19'(signed'({1'b0, sy[2] - sy[0]}));

		// flat triangle
		priority if (eq12) begin
			ax_f = x_q[2]; ay_f = y_q[2];
			px_f = x_q[0]; py_f = y_q[0]; qx_f = x_q[1];
		end else if (eq13) begin
			ax_f = x_q[1]; ay_f = y_q[1];
			px_f = x_q[0]; py_f = y_q[0]; qx_f = x_q[2];
		end else begin
			ax_f = x_q[0]; ay_f = y_q[0];
			px_f = x_q[1]; py_f = y_q[1]; qx_f = x_q[2];
		end
		dyf = signed'({1'b0, ay_f}) - signed'({1'b0, py_f});
		flat_job.apex_x = ax_f;
		flat_job.p_x    = px_f;
		flat_job.q_x    = qx_f;
		flat_job.p_y    = py_f;
		flat_job.up     = dyf[YW];
		flat_job.rows   = dyf[YW] ? YW'(-dyf) : dyf[YW-1:0];
		flat_job.last   = 1'b1;
	end

	assign div_start = (state_q == F_START);
	assign div_num   = n_q[18] ? ~n_q[tsf_pkg::CUT_NW-1:0] : n_q[tsf_pkg::CUT_NW-1:0];

	tsf_div #(
		.NW(tsf_pkg::CUT_NW),
		.DW(tsf_pkg::CUT_DW)
	) u_cut_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (d_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_comb begin
		// floor division of a negative numerator comes out as the complement
		q_s     = n_q[18] ? ~signed'({2'b00, div_quot}) : signed'({2'b00, div_quot});
		cut_sum = 19'({9'b0, sx_q[0]}) + unsigned'(q_s);

		job1_c.apex_x = sx_q[0];
		job1_c.p_x    = sx_q[1];
		job1_c.q_x    = cut_sum[XW-1:0];
		job1_c.p_y    = sy_q[1];
		job1_c.rows   = sy_q[1] - sy_q[0];
		job1_c.up     = 1'b1;
		job1_c.last   = 1'b0;

		job2_c.apex_x = sx_q[2];
		job2_c.p_x    = sx_q[1];
		job2_c.q_x    = cut_sum[XW-1:0];
		job2_c.p_y    = sy_q[1];
		job2_c.rows   = sy_q[2] - sy_q[1];
		job2_c.up     = 1'b0;
		job2_c.last   = 1'b1;
	end

	assign s_tready  = (state_q == F_IDLE);
	assign job_valid = (state_q == F_PUSH1) || (state_q == F_PUSH2);
	assign job       = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE:  if (s_tvalid) state_q <= F_CLASS;
				F_CLASS: begin
					priority if (all_eq) state_q <= F_IDLE;
					else if (any_eq)     state_q <= F_PUSH2;
					else                 state_q <= F_START;
				end
				F_START: state_q <= F_WAIT;
				F_WAIT:  if (div_done) state_q <= F_PUSH1;
				F_PUSH1: if (job_ready) state_q <= F_PUSH2;
				F_PUSH2: if (job_ready) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && s_tvalid) begin
			x_q[0] <= s_tdata[9:0];
			y_q[0] <= s_tdata[15:10];
			x_q[1] <= s_tdata[25:16];
			y_q[1] <= s_tdata[31:26];
			x_q[2] <= s_tdata[41:32];
			y_q[2] <= s_tdata[47:42];
		end
		if (state_q == F_CLASS) begin
			sx_q  <= sx;
			sy_q  <= sy;
			n_q   <= n_c;
			d_q   <= {sy[2] - sy[0], 1'b0};
			job_q <= flat_job;
		end
		if (state_q == F_WAIT && div_done) begin
			job_q  <= job1_c;
			job2_q <= job2_c;
		end
		if (state_q == F_PUSH1 && job_ready)
			job_q <= job2_q;
	end

endmodule

[rtl/tsf_back.sv]
// back end: works out edge slopes of a fill job and steps out the spans
// depends on tsf_pkg and tsf_div
`timescale 1ns / 1ps

module tsf_back #(
	parameter int SCREEN_WIDTH = tsf_pkg::SCREEN_WIDTH_DEF,
	parameter int BAND_ROWS    = tsf_pkg::BAND_ROWS_DEF,
	parameter int FRAC_BITS    = tsf_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      job_valid,
	output logic                      job_ready,
	input  tsf_pkg::fill_t            job,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [tsf_pkg::OUT_W-1:0] m_tdata,
	output logic                      m_tlast
);

	localparam int XW = tsf_pkg::XW;
	localparam int YW = tsf_pkg::YW;
	localparam int NW = XW + FRAC_BITS;
	localparam int AW = NW + 2;

	typedef enum logic [2:0] {
		B_IDLE,
		B_D1S,
		B_D1W,
		B_D2S,
		B_D2W,
		B_RUN,
		B_FLUSH
	} bstate_t;

	bstate_t state_q;
	logic    pend_v_q;
	logic    m_tvalid_q;

	tsf_pkg::fill_t job_q;
	logic              neg_q;
	logic signed [NW:0] s1_q, s2_q;
	logic signed [AW-1:0] a1_q, a2_q;
	logic [YW-1:0] row_q;
	logic [YW-1:0] k_q;
	logic [YW-1:0] pend_row_q;
	logic [XW-1:0] pend_xl_q, pend_xr_q;
	logic [tsf_pkg::OUT_W-1:0] m_tdata_q;
	logic m_tlast_q;

	logic [XW-1:0] sel_x;
	logic signed [XW:0] diff;
	logic [XW:0]   mag_w;
	logic [NW-1:0] div_num;
	logic [NW-1:0] div_quot;
	logic          div_start;
	logic          div_done;
	logic signed [NW:0] step_c;
	logic [XW-1:0] xl_c, xr_c;
	logic kept, out_free, can_go, run_adv, take_pend, mid_out, flush_out, job_end;

	function automatic logic [XW-1:0] to_pixel(input logic signed [AW-1:0] acc);
		logic [15:0] ip;
		ip = 16'(acc[AW-2:FRAC_BITS]);
		if (acc[AW-1])
			ip = '0;
		else if (ip > 16'(SCREEN_WIDTH - 1))
			ip = 16'(SCREEN_WIDTH - 1);
		return ip[XW-1:0];
	endfunction

	always_comb begin
		sel_x     = (state_q == B_D2S) ? job_q.q_x : job_q.p_x;
		diff      = signed'({1'b0, job_q.apex_x}) - signed'({1'b0, sel_x});
		mag_w     = diff[XW] ? unsigned'(-diff) : unsigned'(diff);
		div_num   = {mag_w[XW-1:0], {FRAC_BITS{1'b0}}};
		div_start = (state_q == B_D1S) || (state_q == B_D2S);
		step_c    = neg_q ? -signed'({1'b0, div_quot}) : signed'({1'b0, div_quot});

		xl_c      = to_pixel(a1_q);
		xr_c      = to_pixel(a2_q);
		kept      = ({1'b0, row_q} < 7'(BAND_ROWS));
		out_free  = !m_tvalid_q || m_tready;
		can_go    = !kept || !pend_v_q || out_free;
		run_adv   = (state_q == B_RUN) && can_go;
		take_pend = run_adv && kept;
		mid_out   = take_pend && pend_v_q;
		flush_out = (state_q == B_FLUSH) && pend_v_q && out_free;
		job_end   = (k_q == job_q.rows - 1'b1);
	end

	tsf_div #(
		.NW(NW),
		.DW(YW)
	) u_slope_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (job_q.rows),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign job_ready = (state_q == B_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tlast   = m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			pend_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (mid_out || flush_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			if (take_pend)
				pend_v_q <= 1'b1;
			else if (flush_out)
				pend_v_q <= 1'b0;
			unique case (state_q)
				B_IDLE:  if (job_valid) state_q <= B_D1S;
				B_D1S:   state_q <= B_D1W;
				B_D1W:   if (div_done) state_q <= B_D2S;
				B_D2S:   state_q <= B_D2W;
				B_D2W:   if (div_done) state_q <= B_RUN;
				B_RUN: begin
					if (run_adv && job_end)
						state_q <= job_q.last ? B_FLUSH : B_IDLE;
				end
				B_FLUSH: if (!pend_v_q || out_free) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && job_valid)
			job_q <= job;
		if (div_start)
			neg_q <= diff[XW];
		if (state_q == B_D1W && div_done)
			s1_q <= step_c;
		if (state_q == B_D2W && div_done) begin
			s2_q  <= step_c;
			a1_q  <= signed'({2'b00, job_q.p_x, {FRAC_BITS{1'b0}}});
			a2_q  <= signed'({2'b00, job_q.q_x, {FRAC_BITS{1'b0}}});
			row_q <= job_q.p_y;
			k_q   <= '0;
		end
		if (run_adv) begin
			a1_q  <= a1_q + AW'(s1_q);
			a2_q  <= a2_q + AW'(s2_q);
			row_q <= job_q.up ? row_q - 1'b1 : row_q + 1'b1;
			k_q   <= k_q + 1'b1;
		end
		if (mid_out || flush_out) begin
			m_tdata_q <= {{(tsf_pkg::OUT_W - 2 * XW - YW){1'b0}},
			              pend_xr_q, pend_xl_q, pend_row_q};
			m_tlast_q <= flush_out;
		end
		if (take_pend) begin
			pend_row_q <= row_q;
			pend_xl_q  <= xl_c;
			pend_xr_q  <= xr_c;
		end
	end

endmodule

[rtl/triangle_scanline_fill.sv]
// triangle scanline fill: one triangle in, its horizontal spans out
// the slope and cut dividers are bit-serial; once stepping starts, the back end gives
// one span per cycle while the output is not stalled
// asynchronous active-low reset clears all control state; no clearing pass
`timescale 1ns / 1ps

module triangle_scanline_fill #(
	parameter int SCREEN_WIDTH = tsf_pkg::SCREEN_WIDTH_DEF,
	parameter int BAND_ROWS    = tsf_pkg::BAND_ROWS_DEF,
	parameter int FRAC_BITS    = tsf_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// ax, ay, bx, by, cx, cy
	input  logic [tsf_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// row, x on the p edge, x on the q edge (either may be the left one), zero fill
	output logic [tsf_pkg::OUT_W-1:0] m_tdata,
	output logic                      m_tlast
);

	tsf_pkg::fill_t f_job, b_job;
	logic f_valid, f_ready, b_valid, b_ready;

	tsf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.job_valid(f_valid),
		.job_ready(f_ready),
		.job      (f_job)
	);

	tsf_fifo u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data (f_job),
		.rd_valid(b_valid),
		.rd_ready(b_ready),
		.rd_data (b_job)
	);

	tsf_back #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.BAND_ROWS   (BAND_ROWS),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(b_valid),
		.job_ready(b_ready),
		.job      (b_job),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

[rtl/tsf_checker.sv]
// port-level checks of the triangle scanline fill, bound to the top level
// depends on tsf_pkg and triangle_scanline_fill_assert.svh
`timescale 1ns / 1ps
`include "triangle_scanline_fill_assert.svh"

module tsf_checker #(
	parameter int SCREEN_WIDTH = tsf_pkg::SCREEN_WIDTH_DEF,
	parameter int BAND_ROWS    = tsf_pkg::BAND_ROWS_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [tsf_pkg::OUT_W-1:0] m_tdata,
	input logic                      m_tlast
);

	`TSF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	`TSF_ASSERT_SAME(a_row_in_band, m_tvalid, {1'b0, m_tdata[5:0]} < 7'(BAND_ROWS))
	`TSF_ASSERT_SAME(a_x_on_screen, m_tvalid && (SCREEN_WIDTH <= 1024), (m_tdata[15:6] <= 10'(SCREEN_WIDTH - 1)) && (m_tdata[25:16] <= 10'(SCREEN_WIDTH - 1)))
	`TSF_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready)

endmodule

bind triangle_scanline_fill tsf_checker #(
	.SCREEN_WIDTH(SCREEN_WIDTH),
	.BAND_ROWS   (BAND_ROWS)
) u_tsf_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

[sim/tsf_span_checker.sv]
// span checker for the triangle scanline fill: watches both streams, predicts spans
// per accepted triangle and compares them in order; depends on tsf_pkg
`timescale 1ns / 1ps

module tsf_span_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [tsf_pkg::IN_W-1:0]  s_tdata,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [tsf_pkg::OUT_W-1:0] m_tdata,
	input  logic                      m_tlast,
	output int                        fail_count,
	output int                        pending
);
	import tsf_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;

	typedef struct packed {
		logic [YW-1:0] row;
		logic [XW-1:0] xl;
		logic [XW-1:0] xr;
		logic          last;
	} span_t;

	typedef struct {
		longint x;
		longint y;
	} vert_t;

	span_t span_q[$];
	span_t tri_spans[$];

	function automatic longint edge_pixel(longint acc);
		longint v;
		if (acc < 0)
			return 0;
		v = acc >>> FRAC;
		if (v > SCREEN_WIDTH_DEF - 1)
			v = SCREEN_WIDTH_DEF - 1;
		return v;
	endfunction

	function automatic longint div_floor(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d != 0) && ((n < 0) != (d < 0)))
			q -= 1;
		return q;
	endfunction

	task automatic step_edges(vert_t apex, vert_t p, vert_t q);
		longint dy, dir, rows, s1, s2, a1, a2;
		span_t sp;
		dy = apex.y - p.y;
		dir = (dy > 0) ? 1 : -1;
		rows = (dy > 0) ? dy : -dy;
		if (rows == 0)
			return;
		s1 = ((apex.x - p.x) * (longint'(1) << FRAC)) / rows;
		s2 = ((apex.x - q.x) * (longint'(1) << FRAC)) / rows;
		a1 = p.x << FRAC;
		a2 = q.x << FRAC;
		for (longint k = 0; k < rows; k++) begin
			sp.row = YW'(p.y + k * dir);
			sp.xl = XW'(edge_pixel(a1));
			sp.xr = XW'(edge_pixel(a2));
			sp.last = 1'b0;
			if (p.y + k * dir >= 0 && p.y + k * dir < BAND_ROWS_DEF && tri_spans.size() < 64)
				tri_spans = {tri_spans, sp};
			a1 += s1;
			a2 += s2;
		end
	endtask

	task automatic predict_triangle(logic [IN_W-1:0] d);
		vert_t v1, v2, v3, t, cut;
		longint num, den;
		v1.x = d[9:0];   v1.y = d[15:10];
		v2.x = d[25:16]; v2.y = d[31:26];
		v3.x = d[41:32]; v3.y = d[47:42];
		tri_spans.delete();
		if (v1.y == v2.y && v1.y == v3.y) begin
		end else if (v1.y == v2.y) begin
			step_edges(v3, v1, v2);
		end else if (v1.y == v3.y) begin
			step_edges(v2, v1, v3);
		end else if (v2.y == v3.y) begin
			step_edges(v1, v2, v3);
		end else begin
			if (v1.y > v2.y) begin t = v1; v1 = v2; v2 = t; end
			if (v2.y > v3.y) begin t = v2; v2 = v3; v3 = t; end
			if (v1.y > v2.y) begin t = v1; v1 = v2; v2 = t; end
			num = (v3.x - v1.x) * (v2.y - v1.y);
			den = v3.y - v1.y;
			cut.x = v1.x + div_floor(2 * num + den, 2 * den);
			cut.y = v2.y;
			step_edges(v1, v2, cut);
			step_edges(v3, v2, cut);
		end
		if (tri_spans.size() > 0)
			tri_spans[tri_spans.size()-1].last = 1'b1;
		span_q = {span_q, tri_spans};
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		span_t exp_s, got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_triangle(s_tdata);
			if (m_tvalid && m_tready) begin
				got.row = m_tdata[5:0];
				got.xl = m_tdata[15:6];
				got.xr = m_tdata[25:16];
				got.last = m_tlast;
				if (span_q.size() == 0) begin
					$display("%0t: unexpected span, expected none, actual %h", $time, got);
					fail_count++;
				end else begin
					exp_s = span_q.pop_front();
					if (got != exp_s) begin
						$display("%0t: span mismatch, expected row %0d xl %0d xr %0d last %0d, actual row %0d xl %0d xr %0d last %0d",
							$time, exp_s.row, exp_s.xl, exp_s.xr, exp_s.last,
							got.row, got.xl, got.xr, got.last);
						fail_count++;
					end
				end
			end
		end
		pending = span_q.size();
	end
endmodule

[sim/tb_triangle_scanline_fill.sv]
// testbench top for the triangle scanline fill: drives triangles with random gaps
// and stalls, gives the verdict; depends on tsf_pkg, the block and tsf_span_checker
`timescale 1ns / 1ps

module tb_triangle_scanline_fill;
	import tsf_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;
	logic                m_tlast;
	int                  fail_count;
	int                  pending;
	bit                  calm = 1'b0;
	bit                  hold_sink = 1'b0;

	always #6 clk = ~clk;

	triangle_scanline_fill dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	tsf_span_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.fail_count(fail_count), .pending(pending)
	);

	// packs one request, ax in the lowest bits; tvalid stays up until a gap or a pause
	task automatic send_tri(int ax, int ay, int bx, int by, int cx, int cy);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'(cy), 10'(cx), 6'(by), 10'(bx), 6'(ay), 10'(ax)};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic send_random(int mode);
		int y0, y1;
		case (mode)
			0: send_tri($urandom_range(0, 1023), $urandom_range(0, 63),
				$urandom_range(0, 1023), $urandom_range(0, 63),
				$urandom_range(0, 1023), $urandom_range(0, 63));
			1: begin
				// short triangles, at most four rows tall, keep the number of spans low
				y0 = $urandom_range(0, 59);
				send_tri($urandom_range(0, 1023), y0 + $urandom_range(0, 4),
					$urandom_range(0, 1023), y0 + $urandom_range(0, 4),
					$urandom_range(0, 1023), y0 + $urandom_range(0, 4));
			end
			default: begin
				y0 = $urandom_range(0, 63);
				y1 = $urandom_range(0, 63);
				case ($urandom_range(0, 2))
					0: send_tri($urandom_range(0, 1023), y0, $urandom_range(0, 1023), y0,
						$urandom_range(0, 1023), y1);
					1: send_tri($urandom_range(0, 1023), y0, $urandom_range(0, 1023), y1,
						$urandom_range(0, 1023), y0);
					default: send_tri($urandom_range(0, 1023), y1, $urandom_range(0, 1023), y0,
						$urandom_range(0, 1023), y0);
				endcase
			end
		endcase
	endtask

	// sink side stalls
	always @(posedge clk) begin
		int burst;
		if (!arst_n || calm) begin
			m_tready <= arst_n && !hold_sink;
		end else if (hold_sink) begin
			m_tready <= 1'b0;
		end else if (burst > 0) begin
			burst = burst - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			burst = $urandom_range(1, 17);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// long sink hold-off while triangles keep coming
	initial begin
		wait (arst_n);
		repeat (40) @(posedge clk);
		hold_sink = 1'b1;
		repeat (600) @(posedge clk);
		hold_sink = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("tb_triangle_scanline_fill: done, errors");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, flat top, flat bottom, degenerate, split, tie sorting
		send_tri(0, 0, 1023, 0, 512, 63);
		send_tri(1023, 63, 0, 63, 0, 0);
		send_tri(5, 10, 5, 10, 900, 10);
		send_tri(100, 20, 300, 40, 200, 20);
		send_tri(100, 20, 300, 20, 200, 40);
		send_tri(1023, 5, 0, 0, 0, 5);
		send_tri(0, 0, 1023, 63, 1023, 31);
		send_tri(1023, 63, 0, 0, 0, 32);
		send_tri(10, 3, 20, 1, 30, 2);
		send_tri(30, 2, 10, 3, 20, 1);
		send_tri(20, 1, 30, 2, 10, 3);
		send_tri(0, 0, 1, 1, 3, 2);
		send_tri(682, 21, 341, 42, 1023, 63);
		send_tri(1023, 0, 1023, 63, 0, 1);
		send_tri(0, 62, 1023, 63, 512, 63);
		send_tri(7, 33, 7, 34, 7, 35);
		send_tri(1023, 0, 0, 62, 1023, 63);
		// pause until every span is out
		drain();
		for (int i = 0; i < 130; i++)
			send_random($urandom_range(0, 2));
		calm = 1'b1;
		for (int i = 0; i < 20; i++)
			send_random($urandom_range(0, 2));
		drain();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("tb_triangle_scanline_fill: done, clean");
		else
			$display("tb_triangle_scanline_fill: done, errors");
		$finish;
	end
endmodule
